>>> sv/wicp_pkg.sv
// Package for the channel width parser: width codes, kinds, element ids, record type.
// No dependencies.
package wicp_pkg;
  localparam int WIDE_CHANNELS_DEF = 8;
  localparam int HT_SLOTS_DEF = 2;
  localparam int CAPTURE = 13;

  localparam logic [2:0] W20 = 3'd0;
  localparam logic [2:0] W40P = 3'd1;
  localparam logic [2:0] W40M = 3'd2;
  localparam logic [2:0] W40 = 3'd3;
  localparam logic [2:0] W80 = 3'd4;
  localparam logic [2:0] W160 = 3'd5;
  localparam logic [2:0] W8080 = 3'd6;
  localparam logic [2:0] WUNSET = 3'd7;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_HT = 2'd1;
  localparam logic [1:0] KIND_VHT = 2'd2;
  localparam logic [1:0] KIND_HE = 2'd3;

  localparam logic [7:0] ID_LOAD = 8'd11;
  localparam logic [7:0] ID_HT = 8'd61;
  localparam logic [7:0] ID_VHT = 8'd192;
  localparam logic [7:0] ID_EXT = 8'd255;
  localparam logic [7:0] EXT_HE = 8'd36;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  width_code;
    logic [7:0]  channel_number;
    logic [15:0] sta_count;
    logic [7:0]  chan_util;
    logic [15:0] avail_capacity;
    logic        last_record;
  } rec_t;

  typedef struct packed {
    logic [7:0] ie_byte;
    logic       last_byte;
  } in_t;

  // controller -> datapath
  typedef struct packed {
    logic take;    // consume the input byte
    logic advance; // step report cursor
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rec_valid; // current cursor points at a record
    logic rec_last;  // current record is the final one
  } sts_t;
endpackage

>>> sv/wicp_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type is a parameter.
interface wicp_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/wicp_datapath.sv
// Datapath: element walker, decode, channel stores and report cursor.
// Depends on wicp_pkg.
module wicp_datapath #(
  parameter int WIDE_CHANNELS = 8,
  parameter int HT_SLOTS = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  wicp_pkg::cmd_t cmd,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output wicp_pkg::sts_t sts,
  output wicp_pkg::rec_t rec
);
  import wicp_pkg::*;
  localparam int HALF = WIDE_CHANNELS / 2;
  localparam int NPOS = 1 + HT_SLOTS + 2 * WIDE_CHANNELS;
  localparam int CW = $clog2(NPOS + 1);

  logic [1:0] phase;
  logic [7:0] position, elen, eid;
  logic [7:0] cap [CAPTURE];
  logic [2:0] present;
  logic [2:0] wcode [3];
  logic [7:0] ht [HT_SLOTS];
  logic [7:0] vht [WIDE_CHANNELS];
  logic [7:0] he [WIDE_CHANNELS];
  logic [40:0] load;
  logic [CW-1:0] cursor;
  logic scanning;

  // capture view including the current byte
  logic [7:0] e [CAPTURE];
  logic decode;
  always_comb begin
    for (int i = 0; i < CAPTURE; i++) e[i] = cap[i];
    decode = 1'b0;
    case (phase)
      2'd0: begin
        for (int i = 0; i < CAPTURE; i++) e[i] = 8'd0;
        e[0] = in_byte;
      end
      2'd1: begin
        e[1] = in_byte;
        decode = (in_byte == 8'd0);
      end
      default: begin
        for (int i = 2; i < CAPTURE; i++)
          if (position == 8'(i - 2)) e[i] = in_byte;
        decode = (position + 8'd1 >= elen);
      end
    endcase
  end

  logic [7:0] cur_id;
  assign cur_id = (phase == 2'd0) ? in_byte : eid;

  function automatic logic [7:0] adiff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // VHT info decode into the next store image; entries it does not write keep their values
  function automatic void vinfo(input logic [7:0] cw, input logic [7:0] c0,
                                input logic [7:0] c1, input logic [7:0] h0,
                                input logic [7:0] h1, inout logic [7:0] d [WIDE_CHANNELS],
                                output logic [2:0] w);
    logic [7:0] df;
    df = adiff(c1, c0);
    w = WUNSET;
    if (cw == 8'd0) begin
      w = (h0 != 8'd0 && h1 != 8'd0) ? W40 : W20;
      d[0] = h0;
      d[1] = h1;
    end else if ((cw == 8'd1 && c1 != 8'd0 && df == 8'd8) || cw == 8'd2) begin
      w = W160;
      for (int i = 0; i < WIDE_CHANNELS; i++) d[i] = c0 - 8'd14 + 8'(4 * i);
    end else if ((cw == 8'd1 && (c1 == 8'd0 || df > 8'd16)) || cw == 8'd3) begin
      w = (cw == 8'd1 && c1 == 8'd0) ? W80 : W8080;
      for (int i = 0; i < HALF; i++) d[i] = c0 - 8'd6 + 8'(4 * i);
      if (w == W8080)
        for (int i = 0; i < HALF; i++) d[HALF + i] = c1 - 8'd6 + 8'(4 * i);
    end
  endfunction

  logic [2:0] present_n;
  logic [2:0] wcode_n [3];
  logic [7:0] ht_n [HT_SLOTS];
  logic [7:0] vht_n [WIDE_CHANNELS];
  logic [7:0] he_n [WIDE_CHANNELS];
  logic [40:0] load_n;
  always_comb begin
    logic [7:0] df;
    present_n = present;
    wcode_n = wcode;
    ht_n = ht;
    vht_n = vht;
    he_n = he;
    load_n = load;
    df = adiff(e[12], e[11]);
    if (decode) begin
      if (cur_id == ID_LOAD) begin
        load_n = {1'b1, e[6], e[5], e[4], e[3], e[2]};
      end else if (cur_id == ID_HT) begin
        present_n[0] = 1'b1;
        ht_n[0] = e[2];
        if (e[3][2]) begin
          case (e[3][1:0])
            2'd0: wcode_n[0] = W20;
            2'd1: begin wcode_n[0] = W40P; ht_n[1] = e[2] + 8'd4; end
            2'd3: begin wcode_n[0] = W40M; ht_n[1] = e[2] + 8'd252; end
            default: ;
          endcase
        end else begin
          wcode_n[0] = W20;
        end
      end else if (cur_id == ID_VHT) begin
        present_n[1] = 1'b1;
        vinfo(e[2], e[3], e[4], ht[0], ht[1], vht_n, wcode_n[1]);
      end else if (cur_id == ID_EXT && e[2] == EXT_HE) begin
        present_n[2] = 1'b1;
        if (e[5][1]) begin
          if (e[10] == 8'd0) begin
            wcode_n[2] = W20;
            he_n[0] = e[9];
          end else if (e[10] == 8'd1) begin
            wcode_n[2] = W40;
            for (int i = 0; i < 2; i++) he_n[i] = e[11] - 8'd2 + 8'(4 * i);
          end else if (e[10] == 8'd2 || (e[10] == 8'd3 && e[12] != 8'd0 && df > 8'd16)) begin
            wcode_n[2] = (e[10] == 8'd2) ? W80 : W8080;
            for (int i = 0; i < HALF; i++) he_n[i] = e[11] - 8'd6 + 8'(4 * i);
            if (e[10] == 8'd3)
              for (int i = 0; i < HALF; i++) he_n[HALF + i] = e[12] - 8'd6 + 8'(4 * i);
          end else if (e[10] == 8'd3 && e[12] != 8'd0 && df == 8'd8) begin
            wcode_n[2] = W160;
            for (int i = 0; i < WIDE_CHANNELS; i++) he_n[i] = e[11] - 8'd14 + 8'(4 * i);
          end
        end else if (present[1]) begin
          wcode_n[2] = wcode[1];
          he_n = vht;
        end else if (e[4][2]) begin
          vinfo(e[9], e[10], e[11], ht[0], ht[1], he_n, wcode_n[2]);
        end else if (present[0]) begin
          wcode_n[2] = wcode[0];
          he_n[0] = ht[0];
          he_n[1] = ht[1];
        end
      end
    end
  end

  // report positions: 0 load, then ht slots, vht, he
  logic [NPOS-1:0] pv;
  logic [7:0] pch [NPOS];
  logic [1:0] pk [NPOS];
  logic [2:0] pw [NPOS];
  always_comb begin
    pv[0] = 1'b1;
    pch[0] = 8'd0;
    pk[0] = KIND_LOAD;
    pw[0] = W20;
    for (int i = 0; i < HT_SLOTS; i++) begin
      pch[1 + i] = ht[i];
      pk[1 + i] = KIND_HT;
      pw[1 + i] = wcode[0];
      pv[1 + i] = present[0] && (i == 0 || ht[i] != 8'd0);
    end
    for (int i = 0; i < WIDE_CHANNELS; i++) begin
      pch[1 + HT_SLOTS + i] = vht[i];
      pk[1 + HT_SLOTS + i] = KIND_VHT;
      pw[1 + HT_SLOTS + i] = wcode[1];
      pv[1 + HT_SLOTS + i] = present[1] && vht[i] != 8'd0
        && (i == 0 || pv[HT_SLOTS + i]);
      pch[1 + HT_SLOTS + WIDE_CHANNELS + i] = he[i];
      pk[1 + HT_SLOTS + WIDE_CHANNELS + i] = KIND_HE;
      pw[1 + HT_SLOTS + WIDE_CHANNELS + i] = wcode[2];
    end
    for (int i = 0; i < WIDE_CHANNELS; i++)
      pv[1 + HT_SLOTS + WIDE_CHANNELS + i] = present[2] && he[i] != 8'd0
        && (i == 0 || pv[HT_SLOTS + WIDE_CHANNELS + i]);
  end

  logic [CW-1:0] cpos;
  assign cpos = cursor;
  logic any_after;
  always_comb begin
    any_after = 1'b0;
    for (int i = 0; i < NPOS; i++)
      if (CW'(i) > cpos && pv[i]) any_after = 1'b1;
  end

  logic [CW-1:0] nxt;
  always_comb begin
    nxt = CW'(NPOS);
    for (int i = NPOS - 1; i >= 0; i--)
      if (CW'(i) > cpos && pv[i]) nxt = CW'(i);
  end

  assign sts.rec_valid = scanning;
  assign sts.rec_last = !any_after;

  always_comb begin
    rec = '0;
    if (cpos == '0) begin
      rec.sta_count = load[15:0];
      rec.chan_util = load[23:16];
      rec.avail_capacity = load[39:24];
    end else begin
      for (int i = 1; i < NPOS; i++)
        if (cpos == CW'(i)) begin
          rec.record_kind = pk[i];
          rec.width_code = pw[i];
          rec.channel_number = pch[i];
        end
    end
    rec.last_record = !any_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      position <= 8'd0;
      elen <= 8'd0;
      eid <= 8'd0;
      for (int i = 0; i < CAPTURE; i++) cap[i] <= 8'd0;
      present <= 3'd0;
      for (int i = 0; i < 3; i++) wcode[i] <= WUNSET;
      for (int i = 0; i < HT_SLOTS; i++) ht[i] <= 8'd0;
      for (int i = 0; i < WIDE_CHANNELS; i++) begin vht[i] <= 8'd0; he[i] <= 8'd0; end
      load <= '0;
      cursor <= '0;
      scanning <= 1'b0;
    end else if (cmd.take) begin
      present <= present_n;
      wcode <= wcode_n;
      ht <= ht_n;
      vht <= vht_n;
      he <= he_n;
      load <= load_n;
      if (in_last) begin
        // end of beacon: reset the walker and start the report
        phase <= 2'd0;
        eid <= 8'd0;
        elen <= 8'd0;
        position <= 8'd0;
        for (int i = 0; i < CAPTURE; i++) cap[i] <= 8'd0;
        scanning <= 1'b1;
        cursor <= '0;
      end else begin
        cap <= e;
        case (phase)
          2'd0: begin eid <= in_byte; phase <= 2'd1; end
          2'd1: begin
            elen <= in_byte;
            position <= 8'd0;
            phase <= decode ? 2'd0 : 2'd2;
          end
          default: begin
            position <= position + 8'd1;
            if (decode) phase <= 2'd0;
          end
        endcase
      end
    end else if (cmd.advance) begin
      if (!any_after) begin
        // report done: return to reset state
        scanning <= 1'b0;
        cursor <= '0;
        present <= 3'd0;
        for (int i = 0; i < 3; i++) wcode[i] <= WUNSET;
        for (int i = 0; i < HT_SLOTS; i++) ht[i] <= 8'd0;
        for (int i = 0; i < WIDE_CHANNELS; i++) begin vht[i] <= 8'd0; he[i] <= 8'd0; end
        load <= '0;
      end else begin
        cursor <= nxt;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.advance |-> scanning)
    else $error("advance without report");
  assert property (@(posedge clk) disable iff (rst) scanning |-> !cmd.take)
    else $error("byte taken during report");
  assert property (@(posedge clk) disable iff (rst) scanning |-> pv[cursor[CW-1:0]])
    else $error("cursor on empty record");
endmodule

>>> sv/wicp_ctrl.sv
// Controller: sequences byte intake and the end-of-beacon report.
// Depends on wicp_pkg.
module wicp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_last,
  output logic           out_valid,
  input  logic           out_ready,
  input  wicp_pkg::sts_t sts,
  output wicp_pkg::cmd_t cmd
);
  import wicp_pkg::*;
  typedef enum logic [1:0] { S_WALK = 2'b01, S_REPORT = 2'b10 } state_t;
  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = (state == S_WALK);
    out_valid = (state == S_REPORT) && sts.rec_valid;
    case (state)
      S_WALK: begin
        cmd.take = in_valid;
        if (in_valid && in_last) state_next = S_REPORT;
      end
      S_REPORT: begin
        cmd.advance = out_ready;
        if (out_ready && sts.rec_last) state_next = S_WALK;
      end
      default: state_next = S_WALK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_WALK;
    else state <= state_next;
  end

  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("intake and report overlap");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && sts.rec_last) |=> in_ready)
    else $error("no return to intake");
  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
endmodule

>>> sv/wlan_ie_channel_width_parser.sv
// Top level of the element channel width parser.
// Depends on wicp_pkg, wicp_if, wicp_ctrl, wicp_datapath.
//  channel | dir | payload
//  in_ch   | in  | ie_byte[8], last_byte
//  out_ch  | out | record_kind, width_code, channel_number, sta_count,
//          |     | chan_util, avail_capacity, last_record
// Bytes are taken one per cycle; each is decoded in the cycle it is accepted.
// After the last byte, intake stops and 1 to 19 records go out, one per cycle
// while out_ch.ready is high; a low ready holds the current record.
// Intake resumes the cycle after the final record is accepted.
// Synchronous reset returns the walker and stores to empty.
module wlan_ie_channel_width_parser #(
  parameter int WIDE_CHANNELS = wicp_pkg::WIDE_CHANNELS_DEF,
  parameter int HT_CHANNEL_SLOTS = wicp_pkg::HT_SLOTS_DEF
) (
  input logic clk,
  input logic rst,
  wicp_if.sink   in_ch,
  wicp_if.source out_ch
);
  import wicp_pkg::*;
  cmd_t cmd;
  sts_t sts;
  rec_t rec;

  wicp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.data.last_byte),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  wicp_datapath #(.WIDE_CHANNELS(WIDE_CHANNELS), .HT_SLOTS(HT_CHANNEL_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .in_byte(in_ch.data.ie_byte), .in_last(in_ch.data.last_byte),
    .sts(sts), .rec(rec)
  );

  assign out_ch.data = rec;
endmodule

>>> dv/tb_wlan_ie_channel_width_parser.sv
// Testbench for wlan_ie_channel_width_parser: beacons of element bytes go in,
// records come out and are checked against an in-bench decoder of the elements.
// Depends on wicp_pkg, wicp_if and the parser RTL.
`timescale 1ns / 1ps

module tb_wlan_ie_channel_width_parser;
  import wicp_pkg::*;

  logic clk;
  logic rst;

  wicp_if #(.payload_t(in_t))  in_ch (clk);
  wicp_if #(.payload_t(rec_t)) out_ch (clk);

  wlan_ie_channel_width_parser dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // decoder state
  logic [1:0] walk_phase;
  logic [7:0] elem_pos;
  logic [7:0] elem_id;
  logic [7:0] elem_len;
  logic [7:0] cap [CAPTURE];
  logic [2:0] present;
  logic [2:0] mode_w [3];
  logic [7:0] ht_ch [2];
  logic [7:0] vht_ch [8];
  logic [7:0] he_ch [8];
  logic [40:0] load_rec;

  rec_t  expected_records [$];
  in_t   pending_bytes [$];
  logic [7:0] beacon_bytes [$];
  int    errors = 0;
  int    bytes_sent = 0;
  int    records_seen = 0;
  int    hold_cnt;
  bit    hold_done;

  function automatic logic [7:0] adiff(logic [7:0] a, logic [7:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic void clear_decoder();
    walk_phase = 0;
    elem_pos = 0;
    elem_id = 0;
    elem_len = 0;
    foreach (cap[i]) cap[i] = 0;
    present = 0;
    foreach (mode_w[i]) mode_w[i] = WUNSET;
    foreach (ht_ch[i]) ht_ch[i] = 0;
    foreach (vht_ch[i]) vht_ch[i] = 0;
    foreach (he_ch[i]) he_ch[i] = 0;
    load_rec = 0;
  endfunction

  // run of channels spaced by four around a centre segment
  function automatic void fill_chans(bit to_he, int first, int count, logic [7:0] centre,
                                     int base);
    logic [7:0] v;
    for (int i = 0; i < count; i++) begin
      v = centre + 8'(base + 4 * i);
      if (to_he) he_ch[first + i] = v;
      else vht_ch[first + i] = v;
    end
  endfunction

  function automatic void vht_decode(bit to_he, logic [7:0] cw, logic [7:0] c0,
                                     logic [7:0] c1);
    logic [7:0] d;
    logic [2:0] w;
    d = adiff(c1, c0);
    w = WUNSET;
    if (cw == 0) begin
      w = (ht_ch[0] != 0 && ht_ch[1] != 0) ? W40 : W20;
      if (to_he) begin he_ch[0] = ht_ch[0]; he_ch[1] = ht_ch[1]; end
      else begin vht_ch[0] = ht_ch[0]; vht_ch[1] = ht_ch[1]; end
    end else if (cw == 1) begin
      if (c1 == 0) begin
        w = W80;
        fill_chans(to_he, 0, 4, c0, -6);
      end else if (d == 8) begin
        w = W160;
        fill_chans(to_he, 0, 8, c0, -14);
      end else if (d > 16) begin
        w = W8080;
        fill_chans(to_he, 0, 4, c0, -6);
        fill_chans(to_he, 4, 4, c1, -6);
      end
    end else if (cw == 2) begin
      w = W160;
      fill_chans(to_he, 0, 8, c0, -14);
    end else if (cw == 3) begin
      w = W8080;
      fill_chans(to_he, 0, 4, c0, -6);
      fill_chans(to_he, 4, 4, c1, -6);
    end
    mode_w[to_he ? 2 : 1] = w;
  endfunction

  function automatic void six_ghz_decode();
    logic [7:0] prim, cw, c0, c1, d;
    prim = cap[9]; cw = cap[10]; c0 = cap[11]; c1 = cap[12];
    d = adiff(c1, c0);
    if (cw == 0) begin
      mode_w[2] = W20;
      he_ch[0] = prim;
    end else if (cw == 1) begin
      mode_w[2] = W40;
      fill_chans(1, 0, 2, c0, -2);
    end else if (cw == 2) begin
      mode_w[2] = W80;
      fill_chans(1, 0, 4, c0, -6);
    end else if (cw == 3 && c1 > 0) begin
      if (d == 8) begin
        mode_w[2] = W160;
        fill_chans(1, 0, 8, c0, -14);
      end else if (d > 16) begin
        mode_w[2] = W8080;
        fill_chans(1, 0, 4, c0, -6);
        fill_chans(1, 4, 4, c1, -6);
      end
    end
  endfunction

  function automatic void decode_elem();
    if (elem_id == ID_LOAD) begin
      load_rec = {1'b1, cap[6], cap[5], cap[4], cap[3], cap[2]};
    end else if (elem_id == ID_HT) begin
      present[0] = 1;
      ht_ch[0] = cap[2];
      if (cap[3][2]) begin
        case (cap[3][1:0])
          2'd0: mode_w[0] = W20;
          2'd1: begin mode_w[0] = W40P; ht_ch[1] = cap[2] + 8'd4; end
          2'd3: begin mode_w[0] = W40M; ht_ch[1] = cap[2] - 8'd4; end
          default: ;  // reserved offset: hold width and slot 1
        endcase
      end else begin
        mode_w[0] = W20;
      end
    end else if (elem_id == ID_VHT) begin
      present[1] = 1;
      vht_decode(0, cap[2], cap[3], cap[4]);
    end else if (elem_id == ID_EXT && cap[2] == EXT_HE) begin
      present[2] = 1;
      if (cap[5][1]) begin
        six_ghz_decode();
      end else if (present[1]) begin
        mode_w[2] = mode_w[1];
        foreach (he_ch[i]) he_ch[i] = vht_ch[i];
      end else if (cap[4][2]) begin
        vht_decode(1, cap[9], cap[10], cap[11]);
      end else if (present[0]) begin
        mode_w[2] = mode_w[0];
        he_ch[0] = ht_ch[0];
        he_ch[1] = ht_ch[1];
      end
    end
  endfunction

  function automatic void push_chan(logic [1:0] kind, logic [2:0] w, logic [7:0] ch);
    rec_t r;
    r = '0;
    r.record_kind = kind;
    r.width_code = w;
    r.channel_number = ch;
    expected_records.push_back(r);
  endfunction

  function automatic void parse_byte(in_t it);
    rec_t r;
    int i;
    if (walk_phase == 0) begin
      foreach (cap[j]) cap[j] = 0;
      elem_id = it.ie_byte;
      cap[0] = it.ie_byte;
      walk_phase = 1;
    end else if (walk_phase == 1) begin
      elem_len = it.ie_byte;
      cap[1] = it.ie_byte;
      elem_pos = 0;
      if (it.ie_byte == 0) begin
        decode_elem();
        walk_phase = 0;
      end else begin
        walk_phase = 2;
      end
    end else begin
      if (int'(elem_pos) + 2 < CAPTURE) cap[elem_pos + 2] = it.ie_byte;
      elem_pos++;
      if (elem_pos >= elem_len) begin
        decode_elem();
        walk_phase = 0;
      end
    end
    if (!it.last_byte) return;
    r = '0;
    r.record_kind = KIND_LOAD;
    r.sta_count = load_rec[15:0];
    r.chan_util = load_rec[23:16];
    r.avail_capacity = load_rec[39:24];
    expected_records.push_back(r);
    if (present[0]) begin
      push_chan(KIND_HT, mode_w[0], ht_ch[0]);
      if (ht_ch[1] != 0) push_chan(KIND_HT, mode_w[0], ht_ch[1]);
    end
    if (present[1])
      for (i = 0; i < 8 && vht_ch[i] != 0; i++) push_chan(KIND_VHT, mode_w[1], vht_ch[i]);
    if (present[2])
      for (i = 0; i < 8 && he_ch[i] != 0; i++) push_chan(KIND_HE, mode_w[2], he_ch[i]);
    expected_records[$].last_record = 1;
    clear_decoder();
  endfunction

  // element builders: v holds the value bytes, v[k] lands at capture index k+2
  task automatic add_elem(input logic [7:0] id, input int len, input logic [7:0] v [16]);
    beacon_bytes.push_back(id);
    beacon_bytes.push_back(8'(len));
    for (int i = 0; i < len; i++)
      beacon_bytes.push_back(i < 16 ? v[i] : 8'($urandom_range(255)));
  endtask

  // flush the beacon, cutting it short when keep is below its size
  task automatic end_beacon(input int keep);
    in_t it;
    int n;
    n = (keep > 0 && keep < beacon_bytes.size()) ? keep : beacon_bytes.size();
    for (int i = 0; i < n; i++) begin
      it.ie_byte = beacon_bytes[i];
      it.last_byte = (i == n - 1);
      pending_bytes.push_back(it);
    end
    beacon_bytes.delete();
  endtask

  task automatic rand_vals(output logic [7:0] v [16]);
    foreach (v[i]) v[i] = 8'($urandom_range(255));
  endtask

  task automatic rand_elem();
    logic [7:0] v [16];
    int sel, len;
    rand_vals(v);
    sel = $urandom_range(9);
    case (sel)
      0, 1: begin
        add_elem(ID_LOAD, ($urandom_range(7) == 0) ? $urandom_range(4) : 5, v);
      end
      2, 3: begin
        v[0] = 8'($urandom_range(1, 200));
        add_elem(ID_HT, ($urandom_range(7) == 0) ? $urandom_range(3) : 22, v);
      end
      4, 5: begin
        v[0] = 8'($urandom_range(4));
        case ($urandom_range(3))
          0: v[2] = 0;
          1: v[2] = v[1] + 8'(($urandom_range(1) ? 8 : -8));
          2: v[2] = v[1] + 8'($urandom_range(17, 120));
          default: ;
        endcase
        add_elem(ID_VHT, 5, v);
      end
      6, 7, 8: begin
        if ($urandom_range(7) != 0) v[0] = EXT_HE;
        v[8] = 8'($urandom_range(4));
        case ($urandom_range(3))
          0: v[10] = 0;
          1: v[10] = v[9] + 8'(($urandom_range(1) ? 8 : -8));
          2: v[10] = v[9] + 8'($urandom_range(17, 120));
          default: ;
        endcase
        // embedded VHT info at v[7..9]
        if ($urandom_range(1)) v[7] = 8'($urandom_range(4));
        len = ($urandom_range(5) == 0) ? $urandom_range(16) : $urandom_range(10, 14);
        add_elem(ID_EXT, len, v);
      end
      default: begin
        add_elem(8'($urandom_range(255)), $urandom_range(20), v);
      end
    endcase
  endtask

  task automatic build_directed();
    logic [7:0] v [16];
    // load, HT 40+, VHT 80, HE 6 GHz 160
    rand_vals(v); v[0] = 8'hFF; v[1] = 8'hFF; v[2] = 8'h00; v[3] = 8'hFF; v[4] = 8'h80;
    add_elem(ID_LOAD, 5, v);
    rand_vals(v); v[0] = 8'd36; v[1] = 8'h05; add_elem(ID_HT, 22, v);
    rand_vals(v); v[0] = 8'd1; v[1] = 8'd42; v[2] = 8'd0; add_elem(ID_VHT, 5, v);
    rand_vals(v); v[0] = EXT_HE; v[3] = 8'h02; v[7] = 8'd37; v[8] = 8'd3; v[9] = 8'd47;
    v[10] = 8'd39; add_elem(ID_EXT, 11, v);
    end_beacon(0);
    // HT 40-, VHT 160 from segment gap, HE reuses VHT
    rand_vals(v); v[0] = 8'd2; v[1] = 8'h07; add_elem(ID_HT, 22, v);
    rand_vals(v); v[0] = 8'd1; v[1] = 8'd255; v[2] = 8'd247; add_elem(ID_VHT, 5, v);
    rand_vals(v); v[0] = EXT_HE; v[3] = 8'h00; add_elem(ID_EXT, 10, v);
    end_beacon(0);
    // HT reserved offset, no VHT element, HE from embedded VHT info
    rand_vals(v); v[0] = 8'd0; v[1] = 8'h06; add_elem(ID_HT, 2, v);
    rand_vals(v); v[0] = EXT_HE; v[2] = 8'h04; v[3] = 8'h00; v[7] = 8'd3; v[8] = 8'd5;
    v[9] = 8'd250; add_elem(ID_EXT, 13, v);
    end_beacon(0);
    // HT without width bit, HE reuses HT, empty load, overlong element
    rand_vals(v); v[0] = 8'd1; v[1] = 8'h00; add_elem(ID_HT, 22, v);
    add_elem(ID_LOAD, 0, v);
    rand_vals(v); add_elem(8'd0, 20, v);
    rand_vals(v); v[0] = EXT_HE; v[2] = 8'h00; v[3] = 8'h00; add_elem(ID_EXT, 10, v);
    end_beacon(0);
    // VHT element cut short by the end of the buffer
    rand_vals(v); v[0] = 8'd2; add_elem(ID_VHT, 5, v);
    end_beacon(4);
  endtask

  task automatic build_random();
    int n;
    while (pending_bytes.size() < 205) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) rand_elem();
      if ($urandom_range(5) == 0) end_beacon($urandom_range(1, beacon_bytes.size()));
      else end_beacon(0);
    end
  endtask

  function automatic int idle_pct(bit recv);
    if (bytes_sent < 70) return recv ? 52 : 22;
    if (bytes_sent < 140) return recv ? 22 : 52;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      clear_decoder();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.data);
        bytes_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct(0)) begin
          in_ch.data <= pending_bytes.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && records_seen >= 20) begin
      hold_done <= 1'b1;
      hold_cnt <= 150;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct(1));
    end
  end

  // monitor
  always @(posedge clk) begin
    rec_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      records_seen++;
      if (expected_records.size() == 0) begin
        $error("unexpected record %p", got);
        errors++;
      end else begin
        want = expected_records.pop_front();
        if (got.record_kind !== want.record_kind) begin
          $error("record_kind exp %0d got %0d", want.record_kind, got.record_kind); errors++;
        end
        if (got.width_code !== want.width_code) begin
          $error("width_code exp %0d got %0d", want.width_code, got.width_code); errors++;
        end
        if (got.channel_number !== want.channel_number) begin
          $error("channel_number exp %0d got %0d", want.channel_number, got.channel_number);
          errors++;
        end
        if (got.sta_count !== want.sta_count) begin
          $error("sta_count exp %0d got %0d", want.sta_count, got.sta_count);
          errors++;
        end
        if (got.chan_util !== want.chan_util) begin
          $error("chan_util exp %0d got %0d", want.chan_util, got.chan_util);
          errors++;
        end
        if (got.avail_capacity !== want.avail_capacity) begin
          $error("avail_capacity exp %0d got %0d", want.avail_capacity,
                 got.avail_capacity);
          errors++;
        end
        if (got.last_record !== want.last_record) begin
          $error("last_record exp %0d got %0d", want.last_record, got.last_record); errors++;
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst = 1'b1;
    build_directed();
    build_random();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_bytes.size() > 0 || in_ch.valid || expected_records.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_records.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
